[design/vbs_pkg.sv]
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared constants, types and the color distance test for the background
// segmenter.
// ----------------------------------------------------------------------------
package vbs_pkg;

    localparam int NUM_SAMPLES = 16;
    localparam int PIXELS      = 65536;

    localparam int PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int SAMP_AW = (PIXELS * NUM_SAMPLES > 1) ? $clog2(PIXELS * NUM_SAMPLES) : 1;
    localparam int KCNT_W  = $clog2(NUM_SAMPLES + 1);
    localparam int COLOR_W = 24;
    localparam int COUNT_W = 6;

    localparam logic [0:0] OP_SEGMENT = 1'b0;
    localparam logic [0:0] OP_WRITE   = 1'b1;

    localparam logic [4:0] SLOT_HIST_FIRST  = 5'd0;
    localparam logic [4:0] SLOT_HIST_SECOND = 5'd1;
    localparam logic [4:0] SLOT_SAMPLE_BASE = 5'd2;

    localparam logic [0:0] REG_THRESHOLD   = 1'b0;
    localparam logic [0:0] REG_MIN_MATCHES = 1'b1;

    localparam logic [7:0] THRESHOLD_RESET   = 8'd20;
    localparam logic [4:0] MIN_MATCHES_RESET = 5'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_HIST_RD,
        ST_HIST_CMP,
        ST_SAMP_RD,
        ST_SAMP_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic write_item;
        logic read_hist;
        logic cmp_hist;
        logic read_sample;
        logic cmp_sample;
        logic write_back;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic scan_more;
        logic out_busy;
    } status_t;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    // L1 distance over three channels against three times the threshold
    function automatic logic near_color(input logic [COLOR_W-1:0] a,
                                        input logic [COLOR_W-1:0] b,
                                        input logic [7:0] thr);
        logic [9:0] l1_sum;
        logic [9:0] limit;
        l1_sum = {2'b00, abs_diff(a[7:0], b[7:0])}
               + {2'b00, abs_diff(a[15:8], b[15:8])}
               + {2'b00, abs_diff(a[23:16], b[23:16])};
        limit = {1'b0, thr, 1'b0} + {2'b00, thr};
        return l1_sum <= limit;
    endfunction

endpackage

[design/vbs_ram.sv]
// ----------------------------------------------------------------------------
// vbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/vbs_ctrl.sv]
// ----------------------------------------------------------------------------
// vbs_ctrl
// Sequencer for one item: model write, or history check followed by the
// sample scan and result hand-off.
// ----------------------------------------------------------------------------
module vbs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  vbs_pkg::status_t status,
    output vbs_pkg::cmd_t    cmd
);

    import vbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // item registers are loaded now; branch on the operation
                state_next = status.is_write ? ST_IDLE : ST_HIST_CMP;
            end
            ST_HIST_RD:    state_next = ST_HIST_CMP;
            ST_HIST_CMP:   state_next = ST_SAMP_RD;
            ST_SAMP_RD:    state_next = status.scan_more ? ST_SAMP_CMP : ST_FINISH;
            ST_SAMP_CMP:   state_next = ST_SAMP_RD;
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_WRITE:
            begin
                // write items commit here; segment items fetch both histories
                cmd.write_item = status.is_write;
                cmd.read_hist  = !status.is_write;
            end
            ST_HIST_RD:    cmd.read_hist = 1'b1;
            ST_HIST_CMP:   cmd.cmp_hist = 1'b1;
            ST_SAMP_RD:    cmd.read_sample = status.scan_more;
            ST_SAMP_CMP:   cmd.cmp_sample = 1'b1;
            ST_FINISH:
            begin
                cmd.write_back  = 1'b1;
                cmd.load_result = !status.out_busy;
            end
            default:       cmd = '0;
        endcase
    end

endmodule

[design/vbs_datapath.sv]
// ----------------------------------------------------------------------------
// vbs_datapath
// Item registers, model memories, match counter, swap register and the
// result register.
// ----------------------------------------------------------------------------
module vbs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vbs_pkg::cmd_t        cmd,
    output vbs_pkg::status_t     status,
    input  logic [7:0]           threshold,
    input  logic [4:0]           min_matches,
    input  logic                 operation,
    input  logic                 frame_start,
    input  logic [15:0]          pixel_index,
    input  logic [4:0]           slot,
    input  logic [7:0]           channel_zero,
    input  logic [7:0]           channel_one,
    input  logic [7:0]           channel_two,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 foreground
);

    import vbs_pkg::*;

    logic                        op_reg;
    logic [PIX_W-1:0]            pix_reg;
    logic [4:0]                  slot_reg;
    logic [COLOR_W-1:0]          color_reg;
    logic                        parity_reg;
    logic                        parity_next;
    logic signed [COUNT_W-1:0]   count_reg;
    logic signed [COUNT_W-1:0]   count_next;
    logic [KCNT_W-1:0]           k_reg;
    logic [KCNT_W-1:0]           k_next;
    logic [COLOR_W-1:0]          target_reg;
    logic [COLOR_W-1:0]          target_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        fg_reg;
    logic                        fg_next;

    logic [COLOR_W-1:0]          hist1_rd_data;
    logic [COLOR_W-1:0]          hist2_rd_data;
    logic [COLOR_W-1:0]          samp_rd_data;
    logic                        hist1_wr_en;
    logic                        hist2_wr_en;
    logic [COLOR_W-1:0]          hist_wr_data;
    logic                        samp_wr_en;
    logic [SAMP_AW-1:0]          samp_base;
    logic [SAMP_AW-1:0]          samp_scan_addr;
    logic [SAMP_AW-1:0]          samp_wr_addr;
    logic [COLOR_W-1:0]          samp_wr_data;
    logic [4:0]                  slot_off;
    logic                        slot_is_sample;
    logic                        hist1_near;
    logic                        hist2_near;
    logic                        samp_near;

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            pix_reg   <= PIX_W'(pixel_index);
            slot_reg  <= slot;
            color_reg <= {channel_two, channel_one, channel_zero};
        end
    end

    always_comb
    begin
        parity_next = parity_reg;
        if (cmd.load && (operation == OP_SEGMENT) && frame_start)
        begin
            parity_next = !parity_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign samp_base      = SAMP_AW'(32'(pix_reg) * NUM_SAMPLES);
    assign samp_scan_addr = samp_base + SAMP_AW'(k_reg);
    assign slot_off       = slot_reg - SLOT_SAMPLE_BASE;
    assign slot_is_sample = (slot_reg >= SLOT_SAMPLE_BASE) && (32'(slot_off) < NUM_SAMPLES);

    assign hist1_near = near_color(hist1_rd_data, color_reg, threshold);
    assign hist2_near = near_color(hist2_rd_data, color_reg, threshold);
    assign samp_near  = near_color(samp_rd_data, color_reg, threshold);

    // counter, scan index and the value that sits in the swap-target history
    always_comb
    begin
        count_next  = count_reg;
        k_next      = k_reg;
        target_next = target_reg;
        if (cmd.cmp_hist)
        begin
            count_next  = COUNT_W'({1'b0, min_matches})
                        - COUNT_W'({5'b0, hist1_near})
                        - COUNT_W'({5'b0, hist2_near});
            k_next      = '0;
            target_next = parity_reg ? hist2_rd_data : hist1_rd_data;
        end
        else if (cmd.cmp_sample)
        begin
            k_next = k_reg + KCNT_W'(1);
            if (samp_near)
            begin
                count_next  = count_reg - COUNT_W'(1);
                target_next = samp_rd_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        k_reg      <= k_next;
        target_reg <= target_next;
        fg_reg     <= fg_next;
    end

    always_comb
    begin
        fg_next        = fg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load_result)
        begin
            fg_next        = count_reg > 0;
            out_valid_next = 1'b1;
        end
    end

    // memory write steering
    always_comb
    begin
        hist1_wr_en  = 1'b0;
        hist2_wr_en  = 1'b0;
        hist_wr_data = target_reg;
        samp_wr_en   = 1'b0;
        samp_wr_addr = samp_scan_addr;
        samp_wr_data = target_reg;
        priority if (cmd.write_item)
        begin
            hist_wr_data = color_reg;
            hist1_wr_en  = (slot_reg == SLOT_HIST_FIRST);
            hist2_wr_en  = (slot_reg == SLOT_HIST_SECOND);
            samp_wr_en   = slot_is_sample;
            samp_wr_addr = samp_base + SAMP_AW'(slot_off);
            samp_wr_data = color_reg;
        end
        else if (cmd.write_back)
        begin
            hist1_wr_en = !parity_reg;
            hist2_wr_en = parity_reg;
        end
        else if (cmd.cmp_sample)
        begin
            // close sample takes the old swap-target value
            samp_wr_en = samp_near;
        end
    end

    vbs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXELS)
    ) u_hist_first (
        .clk     (clk),
        .wr_en   (hist1_wr_en),
        .wr_addr (pix_reg),
        .wr_data (hist_wr_data),
        .rd_en   (cmd.read_hist),
        .rd_addr (pix_reg),
        .rd_data (hist1_rd_data)
    );

    vbs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXELS)
    ) u_hist_second (
        .clk     (clk),
        .wr_en   (hist2_wr_en),
        .wr_addr (pix_reg),
        .wr_data (hist_wr_data),
        .rd_en   (cmd.read_hist),
        .rd_addr (pix_reg),
        .rd_data (hist2_rd_data)
    );

    vbs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXELS * NUM_SAMPLES)
    ) u_samples (
        .clk     (clk),
        .wr_en   (samp_wr_en),
        .wr_addr (samp_wr_addr),
        .wr_data (samp_wr_data),
        .rd_en   (cmd.read_sample),
        .rd_addr (samp_scan_addr),
        .rd_data (samp_rd_data)
    );

    assign status.is_write  = (op_reg == OP_WRITE);
    assign status.scan_more = (count_reg > 0) && (k_reg < KCNT_W'(NUM_SAMPLES));
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign foreground = fg_reg;

endmodule

[design/vibe_background_segmenter_unit.sv]
// ----------------------------------------------------------------------------
// vibe_background_segmenter_unit
// Per-pixel background model with history check, sample scan with swap, and
// model slot writes; configured over an APB-style port.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    operation, frame_start, pixel_index, slot,
//                                   channel_zero, channel_one, channel_two
//  output    out_valid / out_ready  foreground
//  config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
//  A write item passes through ST_IDLE and ST_WRITE. A segment item passes
//  through ST_IDLE, ST_WRITE and ST_HIST_CMP, then for each scanned sample
//  (S of them, 0..NUM_SAMPLES) a sample memory read and a compare and swap,
//  then ST_FINISH. Reset clears the control state, swap parity, output valid
//  flag and config registers; the model memories are not cleared and must be written before use.
//  A finished result waits in the output register; the next item is taken
//  while it waits, and only the hand-off of the following result stalls.
// ----------------------------------------------------------------------------
module vibe_background_segmenter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic        frame_start,
    input  logic [15:0] pixel_index,
    input  logic [4:0]  slot,
    input  logic [7:0]  channel_zero,
    input  logic [7:0]  channel_one,
    input  logic [7:0]  channel_two,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        foreground,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import vbs_pkg::*;

    logic [7:0] threshold_reg;
    logic [7:0] threshold_next;
    logic [4:0] min_matches_reg;
    logic [4:0] min_matches_next;
    logic       cfg_write;
    logic [0:0] reg_index;
    cmd_t       cmd;
    status_t    status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[2];

    always_comb
    begin
        threshold_next   = threshold_reg;
        min_matches_next = min_matches_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_THRESHOLD:   threshold_next   = pwdata[7:0];
                REG_MIN_MATCHES: min_matches_next = pwdata[4:0];
                default:         threshold_next   = threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            min_matches_reg <= MIN_MATCHES_RESET;
        end
        else
        begin
            threshold_reg   <= threshold_next;
            min_matches_reg <= min_matches_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_THRESHOLD:   prdata = {24'b0, threshold_reg};
            REG_MIN_MATCHES: prdata = {27'b0, min_matches_reg};
            default:         prdata = '0;
        endcase
    end

    vbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vbs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .threshold    (threshold_reg),
        .min_matches  (min_matches_reg),
        .operation    (operation),
        .frame_start  (frame_start),
        .pixel_index  (pixel_index),
        .slot         (slot),
        .channel_zero (channel_zero),
        .channel_one  (channel_one),
        .channel_two  (channel_two),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .foreground   (foreground)
    );

endmodule
